// ----- rtl/sha256_pkg.sv -----
// ============================================================================
// SHA-256 stream hasher package
// Shared types, constants and round functions for the SHA-256 hasher.
// ============================================================================
`default_nettype none

package sha256_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_byte;   // write i_byte into the buffer at the byte pointer
        logic count_up;     // advance the byte count
        logic pad_write;    // write a padding byte at the pad pointer
        logic pad_mark;     // this padded block carries the 0x80 marker
        logic pad_len;      // this padded block carries the bit count
        logic init_round;   // load working variables from the hash state
        logic do_round;     // run one compression round
        logic fold;         // add working variables into the hash state
        logic restart;      // reload initial hash, clear count
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] byte_ptr;   // low six bits of the byte count
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sha256_if.sv -----
// ============================================================================
// SHA-256 stream channels
// Valid/ready channels for message items and digest words.
// ============================================================================
`default_nettype none

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        last_word;
    modport source (output valid, digest_word, word_position, last_word, input ready);
    modport sink   (input valid, digest_word, word_position, last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
// ============================================================================
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding and eight-word digest output.
// ============================================================================
// The hasher takes one item per cycle while idle, with at most one byte in it.
// Each full 64-byte block then holds off input while the buffer moves into the
// schedule window over the one buffer read port, the rounds run on the single
// round unit and a fold adds the result into the hash state. The end of a
// message adds one or two padded blocks (a pad sweep over the remaining buffer
// bytes plus compression for each), a fetch of the first digest word and eight
// digest words, one per cycle while the sink is ready; input is held off
// meanwhile.
`default_nettype none

module sha256_stream_hasher (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sha256_in_if.sink    i_in,
    sha256_out_if.source o_out
);

    sha256_pkg::t_cmd    cmd;
    sha256_pkg::t_status status;
    logic [5:0]  pad_ptr;
    logic [5:0]  rd_ptr;
    logic [5:0]  round;
    logic [2:0]  sel;
    logic [31:0] hash_word;

    sha256_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_out(o_out),
        .i_status(status), .i_hash_word(hash_word), .o_cmd(cmd),
        .o_pad_ptr(pad_ptr), .o_rd_ptr(rd_ptr), .o_round(round), .o_sel(sel)
    );

    sha256_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(i_in.data_byte),
        .i_pad_ptr(pad_ptr), .i_rd_ptr(rd_ptr), .i_round(round), .i_sel(sel),
        .o_status(status), .o_hash_word(hash_word)
    );

endmodule

`default_nettype wire

// ----- rtl/sha256_datapath.sv -----
// ============================================================================
// SHA-256 datapath
// Block buffer, byte count, message schedule, round logic and hash state.
// ============================================================================
`default_nettype none

module sha256_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sha256_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]          i_byte,
    input  wire logic [5:0]          i_pad_ptr,
    input  wire logic [5:0]          i_rd_ptr,
    input  wire logic [5:0]          i_round,
    input  wire logic [2:0]          i_sel,
    output sha256_pkg::t_status      o_status,
    output logic [31:0]              o_hash_word
);

    logic [7:0]  r_buf [64];
    logic [7:0]  r_rd_byte;
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [60:0] r_count;
    logic [7:0]  pad_val;
    logic [63:0] bits;
    logic [31:0] w_new;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] w2;
    logic [31:0] w15;

    // Padding byte for the pad pointer: marker, zeros or length byte.
    // The first of two padded blocks holds only the marker, the second only
    // the length.
    assign bits = {r_count, 3'b000};
    always_comb begin
        pad_val = 8'h00;
        if (i_cmd.pad_len && i_pad_ptr >= 6'(sha256_pkg::LEN_POS)) begin
            pad_val = bits[8'(7 - i_pad_ptr[2:0]) * 8 +: 8];
        end
        if (i_cmd.pad_mark && i_pad_ptr == r_count[5:0]) begin
            pad_val = sha256_pkg::PAD_BYTE;
        end
    end

    // Block buffer memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_buf[r_count[5:0]] <= i_byte;
        end else if (i_cmd.pad_write) begin
            r_buf[i_pad_ptr] <= pad_val;
        end
        r_rd_byte <= r_buf[i_rd_ptr];
    end

    // Byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_count <= '0;
        end else if (i_cmd.count_up) begin
            r_count <= r_count + 61'd1;
        end
    end
    assign o_status.byte_ptr = r_count[5:0];

    // Schedule expansion from the rolling window.
    assign w2  = r_w[4'(i_round - 6'd2)];
    assign w15 = r_w[4'(i_round - 6'd15)];
    assign s0  = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    assign s1  = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    assign w_new = s1 + r_w[4'(i_round - 6'd7)] + s0 + r_w[i_round[3:0]];
    assign w_cur = (i_round >= 6'd16) ? w_new : r_w[i_round[3:0]];

    assign t1 = r_v[7] + (sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
              ^ sha256_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::ROUND_K[i_round] + w_cur;
    assign t2 = (sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
              ^ sha256_pkg::rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Schedule window: bytes shift in during load, expanded words during rounds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_round) begin
            if (i_round >= 6'd16) begin
                r_w[i_round[3:0]] <= w_new;
            end
        end else if (i_sel == 3'd1) begin
            r_w[i_pad_ptr[5:2]] <= {r_w[i_pad_ptr[5:2]][23:0], r_rd_byte};
        end
    end

    // Working variables and hash state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::INIT_HASH[i];
            end
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
        if (i_cmd.init_round) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash_word = r_h[i_round[2:0]];

endmodule

`default_nettype wire

// ----- rtl/sha256_ctrl.sv -----
// ============================================================================
// SHA-256 controller
// Sequences byte intake, block load, rounds, padding and digest output.
// ============================================================================
`default_nettype none

module sha256_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    sha256_in_if.sink               i_in,
    sha256_out_if.source            o_out,
    input  wire sha256_pkg::t_status i_status,
    input  wire logic [31:0]        i_hash_word,
    output sha256_pkg::t_cmd        o_cmd,
    output logic [5:0]              o_pad_ptr,
    output logic [5:0]              o_rd_ptr,
    output logic [5:0]              o_round,
    output logic [2:0]              o_sel
);

    sha256_pkg::t_state r_state, n_state;
    logic [6:0] r_cnt, n_cnt;       // load counter (lags the registered buffer read) / round
    logic       r_final, n_final;   // compressing a padded block
    logic       r_last, n_last;     // last padded block
    logic       r_two, n_two;       // a second padded block is needed
    logic       r_mark, n_mark;     // current padded block carries the marker
    logic [5:0] r_pad, n_pad;
    logic       r_ovalid, n_ovalid;
    logic [2:0] r_opos, n_opos;
    logic [31:0] r_oword;
    logic        take;
    logic        full_after;

    assign take = i_in.valid && i_in.ready;
    assign full_after = i_in.has_byte && (i_status.byte_ptr == 6'd63);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_final = r_final;
        n_last = r_last;
        n_two = r_two;
        n_mark = r_mark;
        n_pad = r_pad;
        n_ovalid = r_ovalid;
        n_opos = r_opos;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (take) begin
                    n_final = 1'b0;
                    n_cnt = '0;
                    if (full_after) begin
                        n_state = sha256_pkg::ST_LOAD;
                        n_final = i_in.end_of_message;
                    end else if (i_in.end_of_message) begin
                        n_state = sha256_pkg::ST_PAD;
                        n_pad = i_status.byte_ptr + 6'(i_in.has_byte);
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                n_pad = r_pad + 6'd1;
                if (r_pad == 6'd63) begin
                    n_state = sha256_pkg::ST_LOAD;
                    n_cnt = '0;
                    n_final = 1'b1;
                    n_last = !r_two;
                end
            end
            sha256_pkg::ST_LOAD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_cnt = '0;
                end
            end
            sha256_pkg::ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD: begin
                n_cnt = '0;
                if (!r_final) begin
                    n_state = sha256_pkg::ST_IDLE;
                end else if (r_last) begin
                    n_state = sha256_pkg::ST_EMIT;
                    n_opos = '0;
                end else begin
                    // The marker already went into the first of two padded
                    // blocks; a message ending on a full block still needs it.
                    n_state = sha256_pkg::ST_PAD;
                    n_pad = '0;
                    n_mark = !r_two;
                    n_two = 1'b0;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    if (r_ovalid && r_opos == 3'd7) begin
                        n_ovalid = 1'b0;
                        n_state = sha256_pkg::ST_IDLE;
                    end else begin
                        n_ovalid = 1'b1;
                        if (r_ovalid) begin
                            n_opos = r_opos + 3'd1;
                        end
                    end
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
        // Entering padding from idle: decide whether the length fits.
        if (r_state == sha256_pkg::ST_IDLE && take && !full_after && i_in.end_of_message) begin
            n_two = (i_status.byte_ptr + 6'(i_in.has_byte)) >= 6'd56;
            n_last = 1'b0;
            n_mark = 1'b1;
        end
        if (r_state == sha256_pkg::ST_IDLE && take && full_after && i_in.end_of_message) begin
            n_two = 1'b0;
            n_last = 1'b0;
        end
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_sel = 3'd0;
        o_pad_ptr = r_pad;
        o_rd_ptr = r_cnt[5:0];
        o_round = r_cnt[5:0];
        i_in.ready = 1'b0;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                o_cmd.write_byte = i_in.valid && i_in.has_byte;
                o_cmd.count_up = i_in.valid && i_in.has_byte;
            end
            sha256_pkg::ST_PAD: begin
                o_cmd.pad_write = 1'b1;
                o_cmd.pad_mark = r_mark;
                o_cmd.pad_len = !r_two;
            end
            sha256_pkg::ST_LOAD: begin
                o_pad_ptr = 6'(r_cnt - 7'd1);
                o_sel = (r_cnt != 7'd0) ? 3'd1 : 3'd0;
                o_cmd.init_round = (r_cnt == 7'd64);
                o_sel = (r_cnt == 7'd64) ? 3'd0 : o_sel;
                if (r_cnt == 7'd64) begin
                    o_pad_ptr = 6'd63;
                    o_sel = 3'd1;
                end
            end
            sha256_pkg::ST_ROUND: o_cmd.do_round = 1'b1;
            sha256_pkg::ST_FOLD: o_cmd.fold = 1'b1;
            sha256_pkg::ST_EMIT: begin
                o_round = {3'b000, n_opos};
                o_cmd.restart = (r_ovalid && o_out.ready && r_opos == 3'd7);
            end
            default: ;
        endcase
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_cnt <= '0;
            r_final <= 1'b0;
            r_last <= 1'b0;
            r_two <= 1'b0;
            r_mark <= 1'b0;
            r_pad <= '0;
            r_ovalid <= 1'b0;
            r_opos <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_final <= n_final;
            r_last <= n_last;
            r_two <= n_two;
            r_mark <= n_mark;
            r_pad <= n_pad;
            r_ovalid <= n_ovalid;
            r_opos <= n_opos;
        end
        r_oword <= i_hash_word;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.digest_word = r_oword;
    assign o_out.word_position = r_opos;
    assign o_out.last_word = (r_opos == 3'd7);

endmodule

`default_nettype wire

// ----- rtl/sha256_checker.sv -----
// ============================================================================
// SHA-256 port checker
// Checks digest word ordering and handshake behavior at the top level ports.
// ============================================================================
`default_nettype none

module sha256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        o_out_valid,
    input wire logic        o_out_ready,
    input wire logic [2:0]  o_out_word_position,
    input wire logic        o_out_last_word,
    input wire logic [31:0] o_out_digest_word
);

    // The last flag marks exactly word seven.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_last_word == (o_out_word_position == 3'd7)))
        else $error("last flag does not match word position");

    // Words come out in order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_ready && !o_out_last_word) |=>
        (o_out_valid && o_out_word_position == $past(o_out_word_position) + 3'd1))
        else $error("digest words out of order");

    // No input is taken while a digest is being delivered.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_in_ready)
        else $error("input accepted during digest output");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_ready) |=> (o_out_valid && $stable(o_out_digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid), .o_out_ready(o_out.ready),
    .o_out_word_position(o_out.word_position), .o_out_last_word(o_out.last_word),
    .o_out_digest_word(o_out.digest_word)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// ============================================================================
// SHA-256 stream hasher testbench
// Drives byte items and end-of-message markers into the hasher, predicts the
// eight digest words of every message and checks each word as it arrives.
// ============================================================================
`default_nettype none

module testbench;

    // Expected digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_position;
        logic        last_word;
    } t_digest_item;

    // Software SHA-256 that predicts the digest and checks the output words.
    class digest_scoreboard;
        logic [31:0]  hash_words [8];
        logic [7:0]   block_bytes [64];
        logic [60:0]  byte_count;
        t_digest_item pending_words [$];
        int unsigned  error_count;
        int unsigned  message_count;

        function new();
            error_count = 0;
            message_count = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hash_words[i] = sha256_pkg::INIT_HASH[i];
            byte_count = '0;
        endfunction

        function logic [31:0] ror(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One 64-round compression of the current block into the hash state.
        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            for (int t = 0; t < 16; t++)
                w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
            for (int t = 16; t < 64; t++) begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            for (int t = 0; t < 8; t++) v[t] = hash_words[t];
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int t = 0; t < 8; t++) hash_words[t] += v[t];
        endfunction

        // Notes one accepted input item.
        function void note_item(input logic [7:0] data, input logic has, input logic eom);
            logic [63:0] bits;
            int idx;
            t_digest_item d;
            if (has) begin
                block_bytes[byte_count[5:0]] = data;
                byte_count = byte_count + 61'd1;
                if (byte_count[5:0] == 0) compress();
            end
            if (!eom) return;
            bits = {byte_count, 3'b000};
            idx = byte_count[5:0];
            block_bytes[idx++] = sha256_pkg::PAD_BYTE;
            if (idx > sha256_pkg::LEN_POS) begin
                while (idx < 64) block_bytes[idx++] = 8'h00;
                compress();
                idx = 0;
            end
            while (idx < sha256_pkg::LEN_POS) block_bytes[idx++] = 8'h00;
            for (int k = 0; k < 8; k++)
                block_bytes[sha256_pkg::LEN_POS + k] = bits[63 - 8*k -: 8];
            compress();
            for (int k = 0; k < 8; k++) begin
                d.digest_word = hash_words[k];
                d.word_position = k[2:0];
                d.last_word = (k == 7);
                pending_words.push_back(d);
            end
            message_count++;
            restart();
        endfunction

        // Checks one accepted digest word against the oldest expectation.
        function void check_word(input t_digest_item got);
            t_digest_item exp_word;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, got);
                error_count++;
                return;
            end
            exp_word = pending_words.pop_front();
            if (got.digest_word !== exp_word.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         exp_word.digest_word, got.digest_word);
                error_count++;
            end
            if (got.word_position !== exp_word.word_position) begin
                $display("%0t: word_position expected %0d actual %0d", $time,
                         exp_word.word_position, got.word_position);
                error_count++;
            end
            if (got.last_word !== exp_word.last_word) begin
                $display("%0t: last_word expected %b actual %b", $time,
                         exp_word.last_word, got.last_word);
                error_count++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha256_in_if  msg_ch ();
    sha256_out_if dig_ch ();

    sha256_stream_hasher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_ch.sink),
        .o_out   (dig_ch.source)
    );

    digest_scoreboard board = new();
    int unsigned idle_cycles;
    int unsigned items_sent;
    int unsigned hold_off_cycles;
    bit          stimulus_done;

    // Clock with a 12-unit period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = 8'h00;
        msg_ch.has_byte = 1'b0;
        msg_ch.end_of_message = 1'b0;
        dig_ch.ready = 1'b0;
    end

    // Accepted input items go to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && msg_ch.valid && msg_ch.ready)
            board.note_item(msg_ch.data_byte, msg_ch.has_byte, msg_ch.end_of_message);
    end

    // Accepted digest words are checked.
    always @(posedge i_clk) begin
        if (i_rst_n && dig_ch.valid && dig_ch.ready)
            board.check_word({dig_ch.digest_word, dig_ch.word_position, dig_ch.last_word});
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Digest receiver: random stalls, with one long hold-off when asked.
    initial begin
        int waits;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                dig_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end
            waits = (stimulus_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (waits > 0) begin
                dig_ch.ready <= 1'b0;
                repeat (waits) @(posedge i_clk);
            end
            dig_ch.ready <= 1'b1;
            @(posedge i_clk iff dig_ch.valid);
        end
    end

    // Sends one item and waits for its acceptance.
    task automatic send_item(input logic [7:0] data, input logic has, input logic eom,
                             input bit no_gap);
        int waits;
        waits = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (waits > 0) begin
            msg_ch.valid <= 1'b0;
            repeat (waits) @(posedge i_clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= data;
        msg_ch.has_byte <= has;
        msg_ch.end_of_message <= eom;
        @(posedge i_clk iff msg_ch.ready);
        items_sent++;
    endtask

    task automatic drain_digests();
        msg_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Sends a message of the given length with random bytes; the last byte
    // may share the item with the end marker.
    task automatic send_message(input int len, input bit merge_end, input bit no_gap);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, no_gap);
            send_item(8'($urandom), 1'b1, merge_end && (i == len - 1), no_gap);
        end
        if (!merge_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1, no_gap);
    endtask

    initial begin
        int lens [] = '{55, 56, 63, 64};
        idle_cycles = 0;
        items_sent = 0;
        hold_off_cycles = 0;
        stimulus_done = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: an ignored item, an empty message, extreme bytes with a merged and a separate end.
        send_item(8'hff, 1'b0, 1'b0, 0);
        send_item(8'h00, 1'b0, 1'b1, 0);
        send_item(8'h00, 1'b1, 1'b0, 0);
        send_item(8'hff, 1'b1, 1'b1, 0);
        send_item(8'hff, 1'b1, 1'b0, 0);
        send_item(8'h00, 1'b1, 1'b0, 0);
        send_item(8'h5a, 1'b0, 1'b1, 0);
        drain_digests();

        // Padding boundaries: one padded block or two.
        foreach (lens[i]) send_message(lens[i], i[0], 0);
        drain_digests();

        // Receiver holds off while the sender keeps offering short messages.
        hold_off_cycles = 600;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3), 1, 1);
        drain_digests();

        // Random messages, mostly short, some spanning several blocks.
        while (items_sent < 300) begin
            send_message(($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
                                                     : $urandom_range(0, 20),
                         1'($urandom_range(0, 1)), 0);
        end
        msg_ch.valid <= 1'b0;
        stimulus_done = 1;

        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Ran %0d items forming %0d messages, including empty, boundary and",
                 items_sent, board.message_count);
        $display("multi-block messages under random and long output stalls.");
        if (board.error_count == 0 && board.pending_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_stream_hasher.sv
rtl/sha256_checker.sv
bench/testbench.sv
